// File: rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection pipeline.
package rti_pkg;

  // Fixed field widths
  localparam int COORD_W = 20;
  localparam int DIST_W  = 24;
  localparam int THR_W   = 40;

  // Register port geometry: 64-bit data, registers at 8-byte strides
  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = 6;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W   = 3;

  // Register reset values
  localparam logic signed [COORD_W-1:0] DIR_Z_RST = COORD_W'(4096);
  localparam logic [THR_W-1:0]          THR_RST   = THR_W'(68719);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X,
    REG_ORG_Y,
    REG_ORG_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DET_THR
  } cfg_reg_t;

  // One triangle
  typedef struct packed {
    logic signed [COORD_W-1:0] vert0_x;
    logic signed [COORD_W-1:0] vert0_y;
    logic signed [COORD_W-1:0] vert0_z;
    logic signed [COORD_W-1:0] vert1_x;
    logic signed [COORD_W-1:0] vert1_y;
    logic signed [COORD_W-1:0] vert1_z;
    logic signed [COORD_W-1:0] vert2_x;
    logic signed [COORD_W-1:0] vert2_y;
    logic signed [COORD_W-1:0] vert2_z;
  } rti_in_t;

  // One test result
  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
  } rti_out_t;

endpackage

// File: rtl/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle test, fully pipelined, fixed point.
// Throughput: one triangle per cycle unless the output stalls; each divide stage resolves one bit of t.
// Per-stage valid bits with a ready chain; bubbles close up under output stall.
// Reset (rst_n, synchronous): clears all valid bits; ray origin 0, direction +z,
// determinant threshold 68719.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rti_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;        // edge / tvec width
  localparam int PPA  = 2 * CW + 1;    // dir * edge product
  localparam int PQA  = 2 * CW + 2;    // tvec * edge product
  localparam int PW   = 2 * CW + 2;    // pvec width
  localparam int QW   = 2 * CW + 3;    // qvec width
  localparam int K    = CW + 2;        // split point of pvec/qvec
  localparam int QHW  = QW - K;        // upper slice width
  localparam int PPW  = 2 * CW + 4;    // partial product width
  localparam int SW   = 3 * CW + 6;    // dot product width
  localparam int SW1  = SW + 1;
  localparam int RW   = SW + DIST_W + 1; // divider remainder width
  localparam int NDV  = 7;             // stage index of divider entry
  localparam int NST  = DIST_W + 9;

  localparam int OP_DET = 0;
  localparam int OP_UN  = 1;
  localparam int OP_VN  = 2;
  localparam int OP_TN  = 3;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] x);
    return {x[CW-1], x};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic [THR_W-1:0]     thr_r;
  logic                 cfg_wr;
  cfg_reg_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RST;
      thr_r    <= THR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORG_X:   org_r[0] <= pwdata[CW-1:0];
        REG_ORG_Y:   org_r[1] <= pwdata[CW-1:0];
        REG_ORG_Z:   org_r[2] <= pwdata[CW-1:0];
        REG_DIR_X:   dir_r[0] <= pwdata[CW-1:0];
        REG_DIR_Y:   dir_r[1] <= pwdata[CW-1:0];
        REG_DIR_Z:   dir_r[2] <= pwdata[CW-1:0];
        REG_DET_THR: thr_r    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback, zero-extended
  always_comb begin
    case (cfg_idx)
      REG_ORG_X:   prdata = {{(CFG_DW-CW){1'b0}}, org_r[0]};
      REG_ORG_Y:   prdata = {{(CFG_DW-CW){1'b0}}, org_r[1]};
      REG_ORG_Z:   prdata = {{(CFG_DW-CW){1'b0}}, org_r[2]};
      REG_DIR_X:   prdata = {{(CFG_DW-CW){1'b0}}, dir_r[0]};
      REG_DIR_Y:   prdata = {{(CFG_DW-CW){1'b0}}, dir_r[1]};
      REG_DIR_Z:   prdata = {{(CFG_DW-CW){1'b0}}, dir_r[2]};
      REG_DET_THR: prdata = {{(CFG_DW-THR_W){1'b0}}, thr_r};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when empty or when its successor loads
  logic [NST-1:0] vld_r;
  logic [NST:0]   ld;

  always_comb begin
    ld[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      ld[k] = ~vld_r[k] | ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edges and tvec
  logic signed [CW-1:0] v0 [3];
  logic signed [CW-1:0] v1 [3];
  logic signed [CW-1:0] v2 [3];
  logic signed [DW-1:0] s1_e1_nxt [3];
  logic signed [DW-1:0] s1_e2_nxt [3];
  logic signed [DW-1:0] s1_tv_nxt [3];
  logic signed [DW-1:0] s1_e1_r [3];
  logic signed [DW-1:0] s1_e2_r [3];
  logic signed [DW-1:0] s1_tv_r [3];

  always_comb begin
    v0[0] = in_data.vert0_x;
    v0[1] = in_data.vert0_y;
    v0[2] = in_data.vert0_z;
    v1[0] = in_data.vert1_x;
    v1[1] = in_data.vert1_y;
    v1[2] = in_data.vert1_z;
    v2[0] = in_data.vert2_x;
    v2[1] = in_data.vert2_y;
    v2[2] = in_data.vert2_z;
    for (int i = 0; i < 3; i++) begin
      s1_e1_nxt[i] = sx(v1[i]) - sx(v0[i]);
      s1_e2_nxt[i] = sx(v2[i]) - sx(v0[i]);
      s1_tv_nxt[i] = sx(org_r[i]) - sx(v0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_e1_r <= s1_e1_nxt;
      s1_e2_r <= s1_e2_nxt;
      s1_tv_r <= s1_tv_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cross product terms, pvec = dir x e2, qvec = tv x e1
  logic signed [PPA-1:0] s2_pa_nxt [3];
  logic signed [PPA-1:0] s2_pb_nxt [3];
  logic signed [PQA-1:0] s2_qa_nxt [3];
  logic signed [PQA-1:0] s2_qb_nxt [3];
  logic signed [PPA-1:0] s2_pa_r [3];
  logic signed [PPA-1:0] s2_pb_r [3];
  logic signed [PQA-1:0] s2_qa_r [3];
  logic signed [PQA-1:0] s2_qb_r [3];
  logic signed [DW-1:0]  s2_e1_r [3];
  logic signed [DW-1:0]  s2_e2_r [3];
  logic signed [DW-1:0]  s2_tv_r [3];

  always_comb begin
    s2_pa_nxt[0] = PPA'(dir_r[1]) * PPA'(s1_e2_r[2]);
    s2_pb_nxt[0] = PPA'(dir_r[2]) * PPA'(s1_e2_r[1]);
    s2_pa_nxt[1] = PPA'(dir_r[2]) * PPA'(s1_e2_r[0]);
    s2_pb_nxt[1] = PPA'(dir_r[0]) * PPA'(s1_e2_r[2]);
    s2_pa_nxt[2] = PPA'(dir_r[0]) * PPA'(s1_e2_r[1]);
    s2_pb_nxt[2] = PPA'(dir_r[1]) * PPA'(s1_e2_r[0]);
    s2_qa_nxt[0] = PQA'(s1_tv_r[1]) * PQA'(s1_e1_r[2]);
    s2_qb_nxt[0] = PQA'(s1_tv_r[2]) * PQA'(s1_e1_r[1]);
    s2_qa_nxt[1] = PQA'(s1_tv_r[2]) * PQA'(s1_e1_r[0]);
    s2_qb_nxt[1] = PQA'(s1_tv_r[0]) * PQA'(s1_e1_r[2]);
    s2_qa_nxt[2] = PQA'(s1_tv_r[0]) * PQA'(s1_e1_r[1]);
    s2_qb_nxt[2] = PQA'(s1_tv_r[1]) * PQA'(s1_e1_r[0]);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_pa_r <= s2_pa_nxt;
      s2_pb_r <= s2_pb_nxt;
      s2_qa_r <= s2_qa_nxt;
      s2_qb_r <= s2_qb_nxt;
      s2_e1_r <= s1_e1_r;
      s2_e2_r <= s1_e2_r;
      s2_tv_r <= s1_tv_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: finish cross products
  logic signed [PW-1:0] s3_pv_nxt [3];
  logic signed [QW-1:0] s3_qv_nxt [3];
  logic signed [PW-1:0] s3_pv_r [3];
  logic signed [QW-1:0] s3_qv_r [3];
  logic signed [DW-1:0] s3_e1_r [3];
  logic signed [DW-1:0] s3_e2_r [3];
  logic signed [DW-1:0] s3_tv_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_pv_nxt[i] = PW'(s2_pa_r[i]) - PW'(s2_pb_r[i]);
      s3_qv_nxt[i] = QW'(s2_qa_r[i]) - QW'(s2_qb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_pv_r <= s3_pv_nxt;
      s3_qv_r <= s3_qv_nxt;
      s3_e1_r <= s2_e1_r;
      s3_e2_r <= s2_e2_r;
      s3_tv_r <= s2_tv_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: dot product partial products, wide operand split in two slices
  logic signed [DW-1:0]  aop [4][3];
  logic signed [QW-1:0]  bop [4][3];
  logic signed [QHW-1:0] bhi;
  logic signed [K:0]     blo;
  logic signed [PPW-1:0] s4_ph_nxt [4][3];
  logic signed [PPW-1:0] s4_pl_nxt [4][3];
  logic signed [PPW-1:0] s4_ph_r [4][3];
  logic signed [PPW-1:0] s4_pl_r [4][3];

  always_comb begin
    bhi = '0;
    blo = '0;
    for (int i = 0; i < 3; i++) begin
      aop[OP_DET][i] = s3_e1_r[i];
      bop[OP_DET][i] = QW'(s3_pv_r[i]);
      aop[OP_UN][i]  = s3_tv_r[i];
      bop[OP_UN][i]  = QW'(s3_pv_r[i]);
      aop[OP_VN][i]  = sx(dir_r[i]);
      bop[OP_VN][i]  = s3_qv_r[i];
      aop[OP_TN][i]  = s3_e2_r[i];
      bop[OP_TN][i]  = s3_qv_r[i];
    end
    for (int o = 0; o < 4; o++) begin
      for (int i = 0; i < 3; i++) begin
        bhi = bop[o][i][QW-1:K];
        blo = {1'b0, bop[o][i][K-1:0]};
        s4_ph_nxt[o][i] = PPW'(aop[o][i]) * PPW'(bhi);
        s4_pl_nxt[o][i] = PPW'(aop[o][i]) * PPW'(blo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_ph_r <= s4_ph_nxt;
      s4_pl_r <= s4_pl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: recombine slices into full products
  logic signed [SW-1:0] s5_fp_nxt [4][3];
  logic signed [SW-1:0] s5_fp_r [4][3];

  always_comb begin
    for (int o = 0; o < 4; o++) begin
      for (int i = 0; i < 3; i++) begin
        s5_fp_nxt[o][i] = (SW'(s4_ph_r[o][i]) <<< K) + SW'(s4_pl_r[o][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_fp_r <= s5_fp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: dot product sums: det, u, v and t numerators
  logic signed [SW-1:0] s6_sm_nxt [4];
  logic signed [SW-1:0] s6_sm_r [4];

  always_comb begin
    for (int o = 0; o < 4; o++) begin
      s6_sm_nxt[o] = s5_fp_r[o][0] + s5_fp_r[o][1] + s5_fp_r[o][2];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_sm_r <= s6_sm_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: make det positive, flip numerators with it
  logic signed [SW-1:0] s7_sm_nxt [4];
  logic                 s7_zero_nxt;
  logic signed [SW-1:0] s7_sm_r [4];
  logic                 s7_zero_r;

  always_comb begin
    s7_zero_nxt = (s6_sm_r[OP_DET] == '0);
    for (int o = 0; o < 4; o++) begin
      s7_sm_nxt[o] = s6_sm_r[OP_DET][SW-1] ? -s6_sm_r[o] : s6_sm_r[o];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_sm_r   <= s7_sm_nxt;
      s7_zero_r <= s7_zero_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: reject tests, far-hit saturation, divider setup
  logic [RW-1:0]     dv_rem_r  [DIST_W+1];
  logic [SW-1:0]     dv_det_r  [DIST_W+1];
  logic [DIST_W-1:0] dv_q_r    [DIST_W+1];
  logic              dv_miss_r [DIST_W+1];
  logic              dv_done_r [DIST_W+1];

  logic signed [SW-1:0]  thr_s;
  logic signed [SW1-1:0] uv_sum;
  logic [RW-1:0]         num0;
  logic [RW-1:0]         lim0;
  logic                  miss0;
  logic                  sat0;

  always_comb begin
    thr_s  = SW'($signed({1'b0, thr_r}));
    uv_sum = SW1'(s7_sm_r[OP_UN]) + SW1'(s7_sm_r[OP_VN]);
    miss0  = s7_zero_r
          || (s7_sm_r[OP_DET] < thr_s)
          || s7_sm_r[OP_UN][SW-1]
          || (s7_sm_r[OP_DET] < s7_sm_r[OP_UN])
          || s7_sm_r[OP_VN][SW-1]
          || (SW1'(s7_sm_r[OP_DET]) < uv_sum)
          || s7_sm_r[OP_TN][SW-1]
          || (s7_sm_r[OP_TN] == '0);
    num0   = RW'($unsigned(s7_sm_r[OP_TN])) << FRAC_BITS;
    lim0   = RW'($unsigned(s7_sm_r[OP_DET])) << DIST_W;
    sat0   = !miss0 && (num0 >= lim0);
  end

  always_ff @(posedge clk) begin
    if (ld[NDV]) begin
      dv_rem_r[0]  <= num0;
      dv_det_r[0]  <= $unsigned(s7_sm_r[OP_DET]);
      dv_q_r[0]    <= sat0 ? '1 : '0;
      dv_miss_r[0] <= miss0;
      dv_done_r[0] <= miss0 | sat0;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < DIST_W; j++) begin : g_div
    localparam int B = DIST_W - 1 - j;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(dv_det_r[j]) << B;
    assign take = !dv_done_r[j] && (dv_rem_r[j] >= dsh);

    always_ff @(posedge clk) begin
      if (ld[NDV+1+j]) begin
        dv_rem_r[j+1]  <= take ? dv_rem_r[j] - dsh : dv_rem_r[j];
        dv_det_r[j+1]  <= dv_det_r[j];
        dv_q_r[j+1]    <= dv_q_r[j] | (take ? (DIST_W'(1) << B) : '0);
        dv_miss_r[j+1] <= dv_miss_r[j];
        dv_done_r[j+1] <= dv_done_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: a zero quotient is a miss too
  rti_out_t out_nxt;
  rti_out_t out_r;

  always_comb begin
    out_nxt.hit          = !dv_miss_r[DIST_W] && (dv_q_r[DIST_W] != '0);
    out_nxt.hit_distance = out_nxt.hit ? dv_q_r[DIST_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (ld[NST-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // A miss never carries a distance
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_distance == '0)
    else $error("miss with nonzero distance");

  // A hit always carries a nonzero distance
  a_hit_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.hit_distance != '0)
    else $error("hit with zero distance");

  // An accepted triangle always lands in the first stage
  a_in_capture : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted triangle lost at pipeline entry");
`endif

endmodule

// File: tb/ray_triangle_intersect_tb.sv
// Self-checking testbench for the fixed-point ray/triangle intersection block.
`timescale 1ns / 100ps

module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam int FRAC      = 12;
  localparam int PIPE_LAT  = DIST_W + 9;
  localparam int WDOG_MAX  = 20000;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    rti_in_t  tri_in;
    bit       known;
    rti_out_t res;
  } tri_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  rti_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rti_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Shadow copy of the ray registers
  logic signed [COORD_W-1:0] ray_org [3];
  logic signed [COORD_W-1:0] ray_dir [3];
  logic [THR_W-1:0]          det_thr;

  rti_out_t hit_q[$];
  int       err_cnt = 0;
  int       snd_idle = 18;
  int       rcv_idle = 78;
  int       wdog = 0;
  int       n_tri = 0;
  int       n_res = 0;
  int       n_hit = 0;
  int       n_sat = 0;

  ray_triangle_intersect u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact Moller-Trumbore in wide integers; t by integer division
  function automatic rti_out_t trace_tri(rti_in_t t);
    wide_t v0[3], e1[3], e2[3], tv[3], pv[3], qv[3], dr[3];
    wide_t det, un, vn, tn, num;
    rti_out_t r;
    r = '0;
    v0[0] = $signed(t.vert0_x); v0[1] = $signed(t.vert0_y); v0[2] = $signed(t.vert0_z);
    e1[0] = $signed(t.vert1_x) - v0[0];
    e1[1] = $signed(t.vert1_y) - v0[1];
    e1[2] = $signed(t.vert1_z) - v0[2];
    e2[0] = $signed(t.vert2_x) - v0[0];
    e2[1] = $signed(t.vert2_y) - v0[1];
    e2[2] = $signed(t.vert2_z) - v0[2];
    for (int i = 0; i < 3; i++) begin
      tv[i] = wide_t'(ray_org[i]) - v0[i];
      dr[i] = wide_t'(ray_dir[i]);
    end
    pv[0] = dr[1] * e2[2] - dr[2] * e2[1];
    pv[1] = dr[2] * e2[0] - dr[0] * e2[2];
    pv[2] = dr[0] * e2[1] - dr[1] * e2[0];
    qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
    qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
    qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
    det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
    un  = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
    vn  = dr[0] * qv[0] + dr[1] * qv[1] + dr[2] * qv[2];
    tn  = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (det < wide_t'({88'd0, det_thr})) return r;
    if (un < 0 || un > det) return r;
    if (vn < 0 || un + vn > det) return r;
    if (tn <= 0) return r;
    num = tn <<< FRAC;
    if (num >= (det <<< DIST_W)) begin
      r.hit_distance = DIST_SAT;
    end else begin
      num = num / det;
      r.hit_distance = num[DIST_W-1:0];
    end
    r.hit = (r.hit_distance != 0);
    if (!r.hit) r.hit_distance = '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Transfer monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) hit_q = {hit_q, trace_tri(in_data)};
      if (out_valid && out_ready) begin
        n_res++;
        if (hit_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          rti_out_t e;
          e = hit_q.pop_front();
          if (out_data.hit !== e.hit)
            report_mismatch($sformatf("hit got %b exp %b", out_data.hit, e.hit));
          if (out_data.hit_distance !== e.hit_distance)
            report_mismatch($sformatf("hit_distance got %h exp %h",
                                      out_data.hit_distance, e.hit_distance));
          if (e.hit) n_hit++;
          if (e.hit_distance == DIST_SAT) n_sat++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("Watchdog expired with %0d results pending", hit_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rcv_idle);

  task automatic send_tri(rti_in_t t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_tri++;
    // idling schedule follows progress through the run
    if (n_tri == 217) begin
      snd_idle = 78; rcv_idle = 18;
    end else if (n_tri == 434) begin
      snd_idle = 0; rcv_idle = 0;
    end
  endtask

  // Wait for the pipeline to empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hit_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [CFG_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(r) << CFG_IDX_LSB;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ORG_X, REG_ORG_Y, REG_ORG_Z: ray_org[int'(r)] = v[COORD_W-1:0];
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[int'(r) - 3] = v[COORD_W-1:0];
      default: det_thr = v[THR_W-1:0];
    endcase
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                         logic [THR_W-1:0] thr);
    drain();
    cfg_write(REG_ORG_X, CFG_DW'(ox));
    cfg_write(REG_ORG_Y, CFG_DW'(oy));
    cfg_write(REG_ORG_Z, CFG_DW'(oz));
    cfg_write(REG_DIR_X, CFG_DW'(dx));
    cfg_write(REG_DIR_Y, CFG_DW'(dy));
    cfg_write(REG_DIR_Z, CFG_DW'(dz));
    cfg_write(REG_DET_THR, CFG_DW'(thr));
  endtask

  function automatic logic [COORD_W-1:0] rnd_coord();
    return COORD_W'($urandom);
  endfunction

  // Mostly triangles straddling a point on the ray, some pure noise
  function automatic rti_in_t rnd_tri(int spread);
    rti_in_t t;
    int      k, p[3];
    logic [COORD_W-1:0] c[9];
    k = $urandom_range(16384, 1);
    for (int i = 0; i < 3; i++)
      p[i] = int'(ray_org[i]) + ((int'(ray_dir[i]) * k) >>> FRAC);
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(99) < 20)
        c[i] = rnd_coord();
      else
        c[i] = COORD_W'(p[i % 3] + $urandom_range(2 * spread) - spread);
    end
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    return t;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      send_tri(rnd_tri($urandom_range(1) ? 8192 : 512));
  endtask

  // Directed rows; expectations typed only where obvious under the reset ray
  tri_row_t rows[$];

  task automatic add_row(int a0, int a1, int a2, int b0, int b1, int b2,
                         int c0, int c1, int c2, bit known, bit h, int d);
    tri_row_t r;
    r.tri_in = {COORD_W'(a0), COORD_W'(a1), COORD_W'(a2), COORD_W'(b0), COORD_W'(b1),
                COORD_W'(b2), COORD_W'(c0), COORD_W'(c1), COORD_W'(c2)};
    r.known = known;
    r.res.hit = h;
    r.res.hit_distance = DIST_W'(d);
    rows = {rows, r};
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, DIR_Z_RST};
    det_thr = THR_RST;

    // hit straight ahead at t = 1.0, edge of the triangle on the ray
    add_row(-4096, -4096, 4096, 4096, -4096, 4096, -4096, 4096, 4096, 1, 1, 4096);
    // same triangle, reversed winding
    add_row(-4096, -4096, 4096, -4096, 4096, 4096, 4096, -4096, 4096, 1, 1, 4096);
    // degenerate triangle: zero determinant
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    // triangle plane contains the ray direction: parallel
    add_row(4096, -4096, 0, 4096, 4096, 0, 4096, 0, 8192, 1, 0, 0);
    // triangle behind the origin
    add_row(-4096, -4096, -4096, 4096, -4096, -4096, -4096, 4096, -4096, 1, 0, 0);
    // ray passes beside the triangle: u out of range
    add_row(4096, -4096, 4096, 12288, -4096, 4096, 4096, 4096, 4096, 1, 0, 0);
    // ray passes beside the triangle: v below zero
    add_row(-4096, 4096, 4096, 4096, 4096, 4096, -4096, 12288, 4096, 1, 0, 0);
    // triangle through the origin: t is zero
    add_row(-4096, -4096, 0, 4096, -4096, 0, -4096, 4096, 0, 1, 0, 0);
    // tiny triangle near origin, small determinant
    add_row(-1, -1, 4096, 1, -1, 4096, -1, 1, 4096, 0, 0, 0);
    // far plane near the coordinate limit
    add_row(-524288, -524288, 524287, 524287, -524288, 524287, -524288, 524287,
            524287, 0, 0, 0);
    // field extremes
    add_row(524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287,
            524287, 1, 0, 0);
    add_row(-524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288,
            -524288, 1, 0, 0);
    add_row(-524288, 524287, -524288, 524287, -524288, 524287, -524288, 524287,
            -524288, 0, 0, 0);
    add_row(524287, -524288, 1, -524288, 524287, -1, 0, 0, 524287, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_tri(rows[i].tri_in);
      if (rows[i].known && trace_tri(rows[i].tri_in) !== rows[i].res)
        report_mismatch($sformatf("directed row %0d disagrees with predictor", i));
    end
    run_random(140);

    // off-axis ray, threshold at zero
    set_ray(-20000, 30000, -40000, 2365, 2365, 2365, 40'd0);
    run_random(110);
    // coordinate extremes with the largest threshold
    set_ray(524287, -524288, 524287, -524288, 524287, -524288, {THR_W{1'b1}});
    run_random(60);
    // very short direction: far hits saturate
    set_ray(0, 0, 0, 0, 0, 1, 40'd0);
    for (int i = 0; i < 40; i++)
      send_tri({COORD_W'(-4096), COORD_W'(-4096), COORD_W'($urandom_range(8192, 1)),
                COORD_W'(8192), COORD_W'(-4096), COORD_W'($urandom_range(8192, 1)),
                COORD_W'(-4096), COORD_W'(8192), COORD_W'($urandom_range(8192, 1))});
    run_random(60);
    // random rays
    for (int p = 0; p < 4; p++) begin
      set_ray($signed(rnd_coord()) >>> 4, $signed(rnd_coord()) >>> 4,
              $signed(rnd_coord()) >>> 4, $signed(rnd_coord()) >>> 6,
              $signed(rnd_coord()) >>> 6, $signed(rnd_coord()) >>> 6,
              {$urandom_range(3) == 0 ? 8'h00 : 8'h00, 32'($urandom_range(200000))});
      run_random(60);
    end

    // final drain
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);

    $display("Sent %0d triangles over 8 ray settings; %0d results, %0d hits, %0d saturated.",
             n_tri, n_res, n_hit, n_sat);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", err_cnt);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
